// ----- design/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// condition must never hold
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)

`define ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

// ----- design/pas_pkg.sv -----
package pas_pkg;

   localparam int ALARMS_DEF    = 16;
   localparam int MAX_FIRES_DEF = 64;

   typedef enum logic [0:0] {
      OP_LOAD = 1'b0,
      OP_TICK = 1'b1
   } pas_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SETTLE,
      ST_DECIDE,
      ST_FLUSH
   } pas_state_type;

   typedef struct packed {
      pas_op_type  opcode;
      logic [3:0]  slot;
      logic [31:0] start_delay;
      logic [31:0] period;
      logic [3:0]  task_id;
      logic        has_task;
      logic [31:0] event_mask;
      logic [31:0] now_ms;
   } pas_req_type;

   typedef struct packed {
      logic [3:0]  fired_slot;
      logic [3:0]  out_task;
      logic        out_has_task;
      logic [31:0] out_mask;
      logic        last;
   } pas_rsp_type;

   // per-slot attributes written only by a load
   typedef struct packed {
      logic [31:0] interval;
      logic [3:0]  task_id;
      logic        has_task;
      logic [31:0] mask;
   } pas_attr_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic tick;
      logic scan_init;
      logic scan_rd;
      logic fire;
      logic flush;
   } pas_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic found;
      logic out_free;
      logic pend_valid;
      logic scan_done;
      logic cap_hit;
   } pas_stat_type;

endpackage

// ----- design/pas_dp.sv -----
module pas_dp import pas_pkg::*; #(
   parameter int ALARMS    = ALARMS_DEF,
   parameter int MAX_FIRES = MAX_FIRES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  pas_req_type  req_data,
   input  pas_cmd_type  cmd,
   output pas_stat_type stat,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output pas_rsp_type  rsp_data
);

   localparam int IW = (ALARMS > 1) ? $clog2(ALARMS) : 1;
   localparam int CW = $clog2(MAX_FIRES + 1);

   // slot memories
   logic [31:0]  dl_mem_ff   [ALARMS];
   pas_attr_type attr_mem_ff [ALARMS];

   logic [ALARMS-1:0] used_ff, used_in;
   logic [IW-1:0]     idx_ff, idx_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [IW-1:0]     rd_idx_ff;
   logic [31:0]       rd_dl_ff;
   pas_attr_type      rd_attr_ff;
   logic              best_vld_ff, best_vld_in;
   logic [IW-1:0]     best_idx_ff, best_idx_in;
   logic [31:0]       best_dl_ff, best_dl_in;
   pas_attr_type      best_attr_ff, best_attr_in;
   logic [31:0]       now_ff, now_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   pas_rsp_type       pend_ff, pend_in;
   logic              pend_vld_ff, pend_vld_in;
   pas_rsp_type       rsp_ff, rsp_in;
   logic              rsp_vld_ff, rsp_vld_in;

   logic          ld_ok;
   logic [IW-1:0] ld_idx;
   logic [31:0]   ld_dl;
   logic          take;
   logic          push;

   // load decode
   assign ld_ok  = ({28'd0, req_data.slot} < 32'(ALARMS));
   assign ld_idx = IW'(req_data.slot);
   assign ld_dl  = (req_data.start_delay != 32'd0) ? req_data.start_delay : req_data.period;

   // memory write and registered scan read
   always_ff @(posedge clock) begin
      if (cmd.load && ld_ok) begin
         dl_mem_ff[ld_idx]   <= ld_dl;
         attr_mem_ff[ld_idx] <= '{interval: req_data.period, task_id: req_data.task_id,
                                  has_task: req_data.has_task, mask: req_data.event_mask};
      end else if (cmd.fire) begin
         dl_mem_ff[best_idx_ff] <= best_dl_ff + best_attr_ff.interval;
      end
      rd_dl_ff   <= dl_mem_ff[idx_ff];
      rd_attr_ff <= attr_mem_ff[idx_ff];
      rd_idx_ff  <= idx_ff;
   end

   // running minimum, strict compare keeps the lowest slot on ties
   assign take = rd_vld_ff && used_ff[rd_idx_ff] && (!best_vld_ff || (rd_dl_ff < best_dl_ff));
   assign push = (cmd.fire && pend_vld_ff) || cmd.flush;

   // next state of the datapath registers
   always_comb begin
      used_in      = used_ff;
      idx_in       = idx_ff;
      rd_vld_in    = 1'b0;
      best_vld_in  = best_vld_ff;
      best_idx_in  = best_idx_ff;
      best_dl_in   = best_dl_ff;
      best_attr_in = best_attr_ff;
      now_in       = now_ff;
      cnt_in       = cnt_ff;
      pend_in      = pend_ff;
      pend_vld_in  = pend_vld_ff;
      rsp_in       = rsp_ff;
      rsp_vld_in   = rsp_vld_ff && rsp_stall;

      if (cmd.load && ld_ok) begin
         used_in[ld_idx] = 1'b1;
      end
      if (cmd.tick) begin
         now_in = req_data.now_ms;
         cnt_in = '0;
      end
      if (take) begin
         best_vld_in  = 1'b1;
         best_idx_in  = rd_idx_ff;
         best_dl_in   = rd_dl_ff;
         best_attr_in = rd_attr_ff;
      end
      if (cmd.scan_rd) begin
         rd_vld_in = 1'b1;
         idx_in    = idx_ff + IW'(1);
      end
      if (cmd.scan_init) begin
         idx_in      = '0;
         best_vld_in = 1'b0;
      end
      // older pending firing moves out as soon as a newer one exists, or on a flush
      if (push) begin
         rsp_in      = pend_ff;
         rsp_in.last = cmd.flush;
         rsp_vld_in  = 1'b1;
      end
      if (cmd.fire) begin
         pend_in     = '{fired_slot: 4'(best_idx_ff), out_task: best_attr_ff.task_id,
                         out_has_task: best_attr_ff.has_task, out_mask: best_attr_ff.mask,
                         last: 1'b0};
         pend_vld_in = 1'b1;
         cnt_in      = cnt_ff + CW'(1);
      end else if (cmd.flush) begin
         pend_vld_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff     <= '0;
         idx_ff      <= '0;
         rd_vld_ff   <= 1'b0;
         best_vld_ff <= 1'b0;
         cnt_ff      <= '0;
         pend_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         used_ff     <= used_in;
         idx_ff      <= idx_in;
         rd_vld_ff   <= rd_vld_in;
         best_vld_ff <= best_vld_in;
         cnt_ff      <= cnt_in;
         pend_vld_ff <= pend_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      best_idx_ff  <= best_idx_in;
      best_dl_ff   <= best_dl_in;
      best_attr_ff <= best_attr_in;
      now_ff       <= now_in;
      pend_ff      <= pend_in;
      rsp_ff       <= rsp_in;
   end

   // status back to the controller
   assign stat.found      = best_vld_ff && (best_dl_ff <= now_ff);
   assign stat.out_free   = !rsp_vld_ff || !rsp_stall;
   assign stat.pend_valid = pend_vld_ff;
   assign stat.scan_done  = (idx_ff == IW'(ALARMS - 1));
   assign stat.cap_hit    = (cnt_ff == CW'(MAX_FIRES - 1));

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- design/pas_ctrl.sv -----
module pas_ctrl import pas_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  pas_op_type   req_op,
   output logic         req_stall,
   input  pas_stat_type stat,
   output pas_cmd_type  cmd
);

   pas_state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_op == OP_TICK)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (stat.scan_done) begin
               state_in = ST_SETTLE;
            end
         end
         ST_SETTLE: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (stat.found) begin
               if (!stat.pend_valid || stat.out_free) begin
                  state_in = stat.cap_hit ? ST_FLUSH : ST_SCAN;
               end
            end else begin
               state_in = stat.pend_valid ? ST_FLUSH : ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_op == OP_TICK) begin
                  cmd.tick      = 1'b1;
                  cmd.scan_init = 1'b1;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_rd = 1'b1;
         end
         ST_SETTLE: begin
         end
         ST_DECIDE: begin
            if (stat.found && (!stat.pend_valid || stat.out_free)) begin
               cmd.fire      = 1'b1;
               cmd.scan_init = !stat.cap_hit;
            end
         end
         ST_FLUSH: begin
            cmd.flush = stat.out_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- design/periodic_alarm_scheduler.sv -----
// periodic alarm scheduler
// req channel: one beat is either a load (opcode 0) that writes an alarm slot's
//   period, start delay, task, task flag and event mask, or a tick (opcode 1)
//   carrying the current time in ms.
// rsp channel: one beat per alarm firing, last set on the final firing of a tick.
// a load gives no beat. a tick scans the deadline memory one slot per cycle;
//   each firing takes a full scan, then the settle and decide states. a tick
//   ends when a scan finds no alarm due or when the MAX_FIRES cap is reached.
//   firings beyond the cap wait for the next tick.
// each result beat appears one firing behind its scan, since last is known
//   only after the following scan.
// req_stall is high whenever a tick is being worked on.
// when rsp_stall is high, the output register holds its beat; the block still
//   scans, but waits in decide or flush until its one pending firing can move out.
// reset (synchronous) empties all slots and drops any pending beats; the
//   slot memories themselves are not cleared.
`include "assert_macros.svh"

module periodic_alarm_scheduler import pas_pkg::*; #(
   parameter int ALARMS    = ALARMS_DEF,
   parameter int MAX_FIRES = MAX_FIRES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  pas_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output pas_rsp_type rsp_data
);

   pas_cmd_type  cmd;
   pas_stat_type stat;
   logic         push_out;

   pas_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.opcode),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   pas_dp #(
      .ALARMS    (ALARMS),
      .MAX_FIRES (MAX_FIRES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // a pending firing moves into the output register
   assign push_out = cmd.flush || (cmd.fire && stat.pend_valid);

   // checks
   `ASSERT_NEVER(a_push_into_full, clock, reset, push_out && rsp_valid && rsp_stall)
   `ASSERT_IMPLY(a_fire_only_due, clock, reset, cmd.fire, stat.found)
   `ASSERT_IMPLY(a_idle_no_pending, clock, reset, !req_stall, !stat.pend_valid)

endmodule
